### hdl/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants for the IPD header parser
// Phase and status codes, result and field-unit interface structs,
// header prefix lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package ipd_pkg;

    localparam int MAX_LINE = 4096;
    localparam int BPOS_W   = 13;           // holds 0..MAX_LINE
    localparam int HDR_LEN  = 5;            // "+IPD,"
    localparam int PPOS_W   = 3;
    localparam int ACC_W    = 32;           // magnitude 0..2^31
    localparam int ACC_X_W  = ACC_W + 4;    // room for acc*10+9

    localparam logic [ACC_X_W-1:0] MAG_LIMIT = ACC_X_W'(64'h8000_0000);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PREFIX,
        PH_FIELD1,
        PH_FIELD2,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_PREFIX,
        ST_BAD_FORMAT,
        ST_LINE_END
    } status_t;

    // number stage inside a field
    typedef enum logic [1:0] {
        NS_SKIP,
        NS_SIGN,
        NS_DIGITS
    } num_stage_t;

    typedef struct packed {
        status_t             status;
        logic signed [15:0]  link_id;
        logic signed [31:0]  payload_length;
        logic [12:0]         data_offset;
    } ipd_result_t;

    typedef struct packed {
        logic clear;
        logic take;
    } ipd_field_ctl_t;

    typedef struct packed {
        logic               take_ok;
        logic               can_end;
        logic signed [31:0] value;
    } ipd_field_sts_t;

    function automatic logic [7:0] hdr_char(input logic [PPOS_W-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h2B;  // '+'
            3'd1:    c = 8'h49;  // 'I'
            3'd2:    c = 8'h50;  // 'P'
            3'd3:    c = 8'h44;  // 'D'
            3'd4:    c = 8'h2C;  // ','
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/ipd_field_unit.sv
// ----------------------------------------------------------------------------
// ipd_field_unit: decimal field accumulator
// Whitespace / sign / digit state and saturating x10 accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_field_unit
    import ipd_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [7:0]     char_in,
    input  ipd_field_ctl_t      ctl,
    output ipd_field_sts_t      sts
);

    logic [ACC_W-1:0] accum_reg, accum_next;
    logic             negative_reg, negative_next;
    num_stage_t       stage_reg, stage_next;
    logic             used_reg, used_next;

    logic                is_digit, is_ws, is_sign;
    logic [ACC_X_W-1:0]  acc_x10;
    logic signed [31:0]  value_c;

    assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    assign is_ws    = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
    assign is_sign  = (char_in == CH_PLUS) || (char_in == CH_MINUS);

    // acc*10 + digit as two shifts and adds
    assign acc_x10 = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                   + ACC_X_W'(char_in - CH_ZERO);

    assign sts.take_ok = is_digit || ((stage_reg == NS_SKIP) && (is_ws || is_sign));
    assign sts.can_end = (stage_reg == NS_DIGITS) || !used_reg;
    assign sts.value   = value_c;

    always_comb begin
        if (negative_reg) begin
            value_c = -$signed(accum_reg);
        end else if (accum_reg[ACC_W-1]) begin
            value_c = 32'sh7FFF_FFFF;
        end else begin
            value_c = $signed(accum_reg);
        end
    end

    always_comb begin
        accum_next    = accum_reg;
        negative_next = negative_reg;
        stage_next    = stage_reg;
        used_next     = used_reg;
        if (ctl.clear) begin
            accum_next    = '0;
            negative_next = 1'b0;
            stage_next    = NS_SKIP;
            used_next     = 1'b0;
        end else if (ctl.take) begin
            if (is_digit) begin
                stage_next = NS_DIGITS;
                accum_next = (acc_x10 > MAG_LIMIT) ? ACC_W'(MAG_LIMIT)
                                                   : acc_x10[ACC_W-1:0];
            end else if (stage_reg == NS_SKIP && is_ws) begin
                used_next = 1'b1;
            end else if (stage_reg == NS_SKIP && is_sign) begin
                negative_next = (char_in == CH_MINUS);
                stage_next    = NS_SIGN;
                used_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg    <= '0;
            negative_reg <= 1'b0;
            stage_reg    <= NS_SKIP;
            used_reg     <= 1'b0;
        end else begin
            accum_reg    <= accum_next;
            negative_reg <= negative_next;
            stage_reg    <= stage_next;
            used_reg     <= used_next;
        end
    end

endmodule

`default_nettype wire

### hdl/ipd_parser_core.sv
// ----------------------------------------------------------------------------
// ipd_parser_core: line phase control for the IPD header parser
// Prefix match, field sequencing, byte position and result forming.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_parser_core
    import ipd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [7:0]  char_in,
    input  wire logic        line_begin,
    input  wire logic        line_end,
    output logic             emit,
    output ipd_result_t      result
);

    phase_t             phase_reg, phase_next;
    logic [PPOS_W-1:0]  ppos_reg, ppos_next;
    logic signed [31:0] first_reg, first_next;
    logic [BPOS_W-1:0]  bpos_reg, bpos_next;

    ipd_field_ctl_t     fctl;
    ipd_field_sts_t     fsts;

    // view of the state as seen by this byte (line_begin restarts the line)
    phase_t             ph;
    logic [PPOS_W-1:0]  ppos;
    logic [BPOS_W-1:0]  bpos;
    logic               pre_match, pre_last, is_comma, is_colon, in_field;
    logic [BPOS_W:0]    bpos_inc;
    logic [12:0]        offset;
    logic signed [15:0] link_sat;

    assign ph        = line_begin ? PH_PREFIX : phase_reg;
    assign ppos      = line_begin ? '0 : ppos_reg;
    assign bpos      = line_begin ? '0 : bpos_reg;
    assign pre_match = (char_in == hdr_char(ppos));
    assign pre_last  = (ppos == PPOS_W'(HDR_LEN - 1));
    assign is_comma  = (char_in == CH_COMMA);
    assign is_colon  = (char_in == CH_COLON);
    assign in_field  = (ph == PH_FIELD1) || (ph == PH_FIELD2);
    assign bpos_inc  = {1'b0, bpos} + 1'b1;
    assign offset    = (bpos_inc > (BPOS_W+1)'(MAX_LINE)) ? 13'(MAX_LINE)
                                                          : 13'(bpos_inc);

    always_comb begin
        if (first_reg > 32'sd32767) begin
            link_sat = 16'sh7FFF;
        end else if (first_reg < -32'sd32768) begin
            link_sat = -16'sh8000;
        end else begin
            link_sat = first_reg[15:0];
        end
    end

    ipd_field_unit u_field (
        .aclk    (aclk),
        .aresetn (aresetn),
        .char_in (char_in),
        .ctl     (fctl),
        .sts     (fsts)
    );

    // next state
    always_comb begin
        phase_next = phase_reg;
        ppos_next  = ppos_reg;
        first_next = first_reg;
        bpos_next  = bpos_reg;
        if (step) begin
            phase_next = ph;
            ppos_next  = ppos;
            first_next = line_begin ? '0 : first_reg;
            bpos_next  = bpos;
            unique case (ph)
                PH_PREFIX: begin
                    if (!pre_match) begin
                        phase_next = PH_DONE;
                    end else if (pre_last) begin
                        phase_next = PH_FIELD1;
                    end else begin
                        ppos_next = ppos + 1'b1;
                    end
                end
                PH_FIELD1, PH_FIELD2: begin
                    if (is_comma && ph == PH_FIELD1) begin
                        if (fsts.can_end) begin
                            phase_next = PH_FIELD2;
                            first_next = fsts.value;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end else if (is_colon) begin
                        phase_next = PH_DONE;
                    end else if (!fsts.take_ok) begin
                        phase_next = PH_DONE;
                    end
                end
                PH_IDLE, PH_DONE: begin
                end
                default: begin
                end
            endcase
            if (line_end) begin
                phase_next = PH_IDLE;
            end
            if (ph != PH_IDLE) begin
                bpos_next = bpos_inc[BPOS_W] ? bpos : BPOS_W'(bpos_inc);
                if (bpos_inc > (BPOS_W+1)'(MAX_LINE)) begin
                    bpos_next = BPOS_W'(MAX_LINE);
                end
            end
        end
    end

    // outputs: result and field unit control
    always_comb begin
        emit       = 1'b0;
        result     = '0;
        fctl.clear = 1'b0;
        fctl.take  = 1'b0;
        if (step) begin
            unique case (ph)
                PH_PREFIX: begin
                    if (!pre_match) begin
                        emit          = 1'b1;
                        result.status = ST_BAD_PREFIX;
                    end else if (pre_last) begin
                        fctl.clear = 1'b1;
                    end
                end
                PH_FIELD1, PH_FIELD2: begin
                    if (is_comma && ph == PH_FIELD1) begin
                        if (fsts.can_end) begin
                            fctl.clear = 1'b1;
                        end else begin
                            emit          = 1'b1;
                            result.status = ST_BAD_FORMAT;
                        end
                    end else if (is_colon) begin
                        emit = 1'b1;
                        if (!fsts.can_end) begin
                            result.status = ST_BAD_FORMAT;
                        end else begin
                            result.status         = ST_OK;
                            result.link_id        = (ph == PH_FIELD2) ? link_sat : '0;
                            result.payload_length = fsts.value;
                            result.data_offset    = offset;
                        end
                    end else begin
                        fctl.take = 1'b1;
                        if (!fsts.take_ok) begin
                            emit          = 1'b1;
                            result.status = ST_BAD_FORMAT;
                        end
                    end
                end
                PH_IDLE, PH_DONE: begin
                end
                default: begin
                end
            endcase
            // line over with header still open; the byte that completes
            // the prefix has already moved the line into the first field
            if (line_end && !emit && ph == PH_PREFIX && !pre_last) begin
                emit          = 1'b1;
                result.status = ST_BAD_PREFIX;
            end else if (line_end && !emit && (in_field || ph == PH_PREFIX)) begin
                emit          = 1'b1;
                result.status = ST_LINE_END;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            ppos_reg  <= '0;
            first_reg <= '0;
            bpos_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            ppos_reg  <= ppos_next;
            first_reg <= first_next;
            bpos_reg  <= bpos_next;
        end
    end

endmodule

`default_nettype wire

### hdl/ipd_header_parser_unit.sv
// ----------------------------------------------------------------------------
// ipd_header_parser_unit: "+IPD,<id>,<len>:" header parser, top level
// One line byte per item in, at most one header result per line out.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Ports
//  --------+-----------+----------------------------------------------------
//  input   | in        | s_valid, s_ready, s_char_in, s_line_begin, s_line_end
//  result  | out       | m_valid, m_ready, m_status, m_link_id,
//          |           | m_payload_length, m_data_offset
//
//  Flow: one item per cycle sustained while results are taken; a result
//  passes through two registers after its input item is accepted (the item
//  lands in the input register, then the result register is loaded from it).
//  The per-byte step (prefix compare, x10 accumulate, saturation) sits
//  between the input register and the result register.
//  Reset: synchronous, active low aresetn; parser returns to idle and waits
//  for a line_begin item. No clearing pass.
//  Stalls: the input register advances whenever it is empty or the result
//  register is empty or being taken, so an item can be accepted while a result is taken.
//
`default_nettype none

module ipd_header_parser_unit
    import ipd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_char_in,
    input  wire logic               s_line_begin,
    input  wire logic               s_line_end,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [15:0]      m_link_id,
    output logic signed [31:0]      m_payload_length,
    output logic [12:0]             m_data_offset
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_begin_reg;
    logic        in_end_reg;

    // result register
    logic        out_valid_reg;
    ipd_result_t out_reg;

    logic        advance;   // result register can take a new value
    logic        step;      // the registered item is processed this cycle
    logic        emit;
    ipd_result_t result;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg  <= s_char_in;
            in_begin_reg <= s_line_begin;
            in_end_reg   <= s_line_end;
        end
    end

    ipd_parser_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .char_in    (in_char_reg),
        .line_begin (in_begin_reg),
        .line_end   (in_end_reg),
        .emit       (emit),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_reg.status;
    assign m_link_id        = out_reg.link_id;
    assign m_payload_length = out_reg.payload_length;
    assign m_data_offset    = out_reg.data_offset;

    // blocked input item is never dropped
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input item lost while result register blocked");

    // a header result always points past "+IPD,:"
    a_ok_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_data_offset >= 13'd6)
        else $error("ok result with impossible data offset");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |->
            m_link_id == '0 && m_payload_length == '0 && m_data_offset == '0)
        else $error("error result with nonzero fields");

    // reset empties both registers
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_valid_reg)
        else $error("registers not empty after reset");

endmodule

`default_nettype wire

### dv/ipd_header_parser_unit_test.sv
// ----------------------------------------------------------------------------
// ipd_header_parser_unit_test: self-checking bench for the IPD header parser
// Feeds lines byte by byte over the valid/ready input channel. A local model
// of the parser predicts each header result, and the result channel is
// compared field by field. A short table of hand-picked lines comes first,
// then random lines, mostly well formed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipd_header_parser_unit_test;
    import ipd_pkg::*;

    // ------------------------------------------------------------------------
    // clock, reset, DUT ports
    // ------------------------------------------------------------------------
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_char_in = 8'h00;
    logic               s_line_begin = 1'b0;
    logic               s_line_end = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic signed [15:0] m_link_id;
    logic signed [31:0] m_payload_length;
    logic [12:0]        m_data_offset;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    ipd_header_parser_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_in        (s_char_in),
        .s_line_begin     (s_line_begin),
        .s_line_end       (s_line_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_link_id        (m_link_id),
        .m_payload_length (m_payload_length),
        .m_data_offset    (m_data_offset)
    );

    // ------------------------------------------------------------------------
    // stimulus types and stores
    // ------------------------------------------------------------------------
    localparam string  IPD_TAG    = "+IPD,";
    localparam longint MAG_CAP    = 64'sh8000_0000;   // magnitude clips at 2^31
    localparam int     RAND_ITEMS = 1350;

    // one byte of a line as it goes on the wire; pin >= 0 points at a table
    // row whose result is typed in by hand
    typedef struct {
        logic [7:0] ch;
        logic       first;
        logic       last;
        int         pin;
    } feed_item_t;

    // one directed line
    typedef struct {
        string       text;
        bit          open;      // line_begin on first byte
        bit          close;     // line_end on last byte
        logic [7:0]  tail;      // extra raw byte appended when nonzero
        bit          pinned;    // use the typed result below
        ipd_result_t want;
    } line_row_t;

    feed_item_t  feed_q[$];
    ipd_result_t header_due_q[$];   // predicted headers not yet seen on m_*
    line_row_t   dir_rows[$];

    longint corner_vals[7] = '{64'sd0, 64'sd32767, 64'sd32768, 64'sd65535,
                               64'sd2147483647, 64'sd2147483648, 64'sd4294967295};

    // ------------------------------------------------------------------------
    // parser model state
    // ------------------------------------------------------------------------
    phase_t             cur_phase = PH_IDLE;
    int                 hdr_idx   = 0;      // next prefix byte to match
    longint             mag       = 0;      // field magnitude, clipped
    bit                 neg       = 1'b0;
    num_stage_t         nstage    = NS_SKIP;
    logic signed [31:0] link_val  = '0;     // first field once closed
    bit                 fld_used  = 1'b0;   // blank or sign taken in field
    int                 pos       = 0;      // byte index in line, saturating

    // bookkeeping
    int  mismatch_cnt = 0;
    int  bytes_fed    = 0;
    int  random_items = 0;
    int  status_tally[4] = '{0, 0, 0, 0};
    bit  in_taken     = 1'b0;
    int  cur_pin      = -1;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  sent_cnt     = 0;
    int  gap_pct      = 20;
    int  stall_pct    = 20;
    int  quiet_from   = 32'h7FFF_FFFF;
    bit  quiet        = 1'b0;

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic void field_reset();
        mag      = 0;
        neg      = 1'b0;
        nstage   = NS_SKIP;
        fld_used = 1'b0;
    endfunction

    // signed field value, clipped to int32 on the positive side only
    // (-2^31 is reachable as is)
    function automatic logic signed [31:0] field_num();
        longint v;
        v = neg ? -mag : mag;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        return v[31:0];
    endfunction

    // Advance the parser by one accepted byte. got tells whether this byte
    // settles the line's header; r then holds the result.
    task automatic header_step(input logic [7:0] c, input logic b, input logic e,
                               output bit got, output ipd_result_t r);
        int unsigned off;
        bit          ending;
        got = 1'b0;
        r   = '0;
        if (b) begin
            cur_phase = PH_PREFIX;
            hdr_idx   = 0;
            field_reset();
            link_val  = '0;
            pos       = 0;
        end
        // idle: stray bytes, position does not move either
        if (cur_phase == PH_IDLE)
            return;

        off = (pos + 1 > MAX_LINE) ? MAX_LINE : pos + 1;
        if (cur_phase == PH_PREFIX) begin
            if (c != IPD_TAG[hdr_idx]) begin
                got      = 1'b1;
                r.status = ST_BAD_PREFIX;
            end else if (hdr_idx == HDR_LEN - 1) begin
                cur_phase = PH_FIELD1;
                field_reset();
            end else begin
                hdr_idx++;
            end
        end else if (cur_phase == PH_FIELD1 || cur_phase == PH_FIELD2) begin
            // a field may close when it has digits or is completely empty
            ending = (nstage == NS_DIGITS) || !fld_used;
            if (c == CH_COMMA && cur_phase == PH_FIELD1) begin
                if (ending) begin
                    link_val  = field_num();
                    cur_phase = PH_FIELD2;
                    field_reset();
                end else begin
                    got      = 1'b1;
                    r.status = ST_BAD_FORMAT;
                end
            end else if (c == CH_COLON) begin
                got = 1'b1;
                if (!ending) begin
                    r.status = ST_BAD_FORMAT;
                end else begin
                    r.status         = ST_OK;
                    r.payload_length = field_num();
                    r.data_offset    = off[12:0];
                    // link id only exists in the two-field form
                    if (cur_phase == PH_FIELD2)
                        r.link_id = (link_val > 32767)  ? 16'sh7FFF :
                                    (link_val < -32768) ? 16'sh8000 : link_val[15:0];
                end
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                nstage = NS_DIGITS;
                mag    = mag * 10 + (c - CH_ZERO);
                if (mag > MAG_CAP)
                    mag = MAG_CAP;
            end else if (nstage == NS_SKIP && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                fld_used = 1'b1;
            end else if (nstage == NS_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
                neg      = (c == CH_MINUS);
                nstage   = NS_SIGN;
                fld_used = 1'b1;
            end else begin
                got      = 1'b1;
                r.status = ST_BAD_FORMAT;
            end
        end
        if (got)
            cur_phase = PH_DONE;

        // line end: an undecided line reports now, then back to idle
        if (e) begin
            if (!got && cur_phase == PH_PREFIX) begin
                got      = 1'b1;
                r.status = ST_BAD_PREFIX;
            end else if (!got && (cur_phase == PH_FIELD1 || cur_phase == PH_FIELD2)) begin
                got      = 1'b1;
                r.status = ST_LINE_END;
            end
            cur_phase = PH_IDLE;
        end
        if (pos < MAX_LINE)
            pos++;
    endtask

    // ------------------------------------------------------------------------
    // line building
    // ------------------------------------------------------------------------
    function automatic line_row_t hdr_row(string t, bit o, bit c, logic [7:0] tl,
                                          bit pin, ipd_result_t w);
        line_row_t lr;
        lr.text   = t;
        lr.open   = o;
        lr.close  = c;
        lr.tail   = tl;
        lr.pinned = pin;
        lr.want   = w;
        return lr;
    endfunction

    task automatic append_text(ref logic [7:0] b[$], input string t);
        for (int i = 0; i < t.len(); i++)
            b.push_back(t[i]);
    endtask

    task automatic queue_line(input logic [7:0] b[$], input bit o, input bit c,
                              input int pin);
        feed_item_t it;
        foreach (b[i]) begin
            it.ch    = b[i];
            it.first = o && (i == 0);
            it.last  = c && (i == b.size() - 1);
            it.pin   = pin;
            feed_q.push_back(it);
        end
    endtask

    // bytes likely to upset the parser, plus plain random ones
    function automatic logic [7:0] noise_char();
        case ($urandom_range(5))
            0:       return CH_COMMA;
            1:       return CH_COLON;
            2:       return CH_SPACE;
            3:       return CH_MINUS;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // blanks, sign, digits: each part optional
    task automatic append_field(ref logic [7:0] b[$]);
        int kind;
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(1, 3))
                b.push_back($urandom_range(5) == 5 ? CH_SPACE : 8'(CH_TAB + $urandom_range(4)));
        if ($urandom_range(99) < 25)
            b.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        kind = $urandom_range(99);
        if (kind < 8) begin
            // no digits at all
        end else if (kind < 50) begin
            append_text(b, $sformatf("%0d", $urandom_range(999)));
        end else if (kind < 75) begin
            if ($urandom_range(3) == 0)
                append_text(b, "00");
            append_text(b, $sformatf("%0d", corner_vals[$urandom_range(6)]));
        end else begin
            // ten to fourteen digits, mostly past int32: exercises the clip
            repeat ($urandom_range(10, 14))
                b.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
    endtask

    task automatic add_random_line();
        logic [7:0] b[$];
        int         kind;
        bit         o, c;
        kind = $urandom_range(99);
        if (kind < 70) begin
            append_text(b, IPD_TAG);
            if ($urandom_range(1)) begin
                append_field(b);
                b.push_back(CH_COMMA);
            end
            append_field(b);
            b.push_back(CH_COLON);
            repeat ($urandom_range(6))
                b.push_back(8'($urandom_range(255)));
            if ($urandom_range(99) < 15)
                b[$urandom_range(b.size() - 1)] = noise_char();
            if ($urandom_range(99) < 10)
                b = b[0:$urandom_range(b.size() - 2)];
        end else if (kind < 85) begin
            // partial or complete prefix, then junk
            append_text(b, IPD_TAG.substr(0, $urandom_range(4)));
            repeat ($urandom_range(4))
                b.push_back(noise_char());
        end else begin
            repeat ($urandom_range(1, 10))
                b.push_back(8'($urandom_range(255)));
        end
        // mostly framed; a few lines lack a begin (stray or continuing an
        // abandoned line) or an end (abandoned by the next begin)
        o = ($urandom_range(99) < 95);
        c = ($urandom_range(99) < 92);
        if (o)
            random_items += b.size();
        queue_line(b, o, c, -1);
    endtask

    // ------------------------------------------------------------------------
    // input driver: new item at the falling edge, held until taken
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        feed_item_t it;
        if (aresetn && (!s_valid || in_taken)) begin
            quiet = (sent_cnt >= quiet_from);
            if (gap_left == 0 && feed_q.size() != 0 && !quiet && $urandom_range(99) < gap_pct)
                gap_left = $urandom_range(1, 10);
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (feed_q.size() != 0) begin
                it = feed_q.pop_front();
                s_valid      <= 1'b1;
                s_char_in    <= it.ch;
                s_line_begin <= it.first;
                s_line_end   <= it.last;
                cur_pin = it.pin;
                sent_cnt++;
                // vary idling density; zero is one of the choices
                if (sent_cnt % 64 == 0) begin
                    gap_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
                    stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stall bursts, none in the last stretch
    always @(negedge aclk) begin
        if (stall_left == 0 && !quiet && $urandom_range(99) < stall_pct)
            stall_left = $urandom_range(1, 10);
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        ipd_result_t want, pred;
        bit          got;
        in_taken = aresetn && s_valid && s_ready;

        // check first, so a result can never pair with this edge's item
        if (aresetn && m_valid && m_ready) begin
            status_tally[m_status]++;
            if (header_due_q.size() == 0) begin
                $error("result with nothing pending: status %0d", m_status);
                mismatch_cnt++;
            end else begin
                want = header_due_q.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    mismatch_cnt++;
                end
                if (m_link_id !== want.link_id) begin
                    $error("link_id: expected %0d, got %0d", want.link_id, m_link_id);
                    mismatch_cnt++;
                end
                if (m_payload_length !== want.payload_length) begin
                    $error("payload_length: expected %0d, got %0d",
                           want.payload_length, m_payload_length);
                    mismatch_cnt++;
                end
                if (m_data_offset !== want.data_offset) begin
                    $error("data_offset: expected %0d, got %0d",
                           want.data_offset, m_data_offset);
                    mismatch_cnt++;
                end
            end
        end

        if (in_taken) begin
            bytes_fed++;
            header_step(s_char_in, s_line_begin, s_line_end, got, pred);
            if (got)
                header_due_q.push_back(cur_pin >= 0 ? dir_rows[cur_pin].want : pred);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] b[$];
        int         total;

        // directed lines; typed results where they are obvious
        dir_rows.push_back(hdr_row("x", 0, 1, 8'h00, 0, '0));   // before any line: ignored
        dir_rows.push_back(hdr_row("+IPD,0:", 1, 1, 8'h00, 1,
                                   '{ST_OK, 16'sd0, 32'sd0, 13'd7}));
        dir_rows.push_back(hdr_row("+IPD,2147483647:", 1, 1, 8'h00, 1,
                                   '{ST_OK, 16'sd0, 32'sh7FFF_FFFF, 13'd16}));
        dir_rows.push_back(hdr_row("+IPD,-99999999999,-99999999999:", 1, 1, 8'h00, 1,
                                   '{ST_OK, 16'sh8000, 32'sh8000_0000, 13'd31}));
        dir_rows.push_back(hdr_row("+IPD,99999,+007:", 1, 1, 8'h00, 0, '0));
        dir_rows.push_back(hdr_row("+IQ", 1, 1, 8'h00, 1, '{ST_BAD_PREFIX, 0, 0, 0}));
        dir_rows.push_back(hdr_row("+IP", 1, 1, 8'h00, 1, '{ST_BAD_PREFIX, 0, 0, 0}));
        dir_rows.push_back(hdr_row("+IPD,\t-12", 1, 1, 8'h00, 1, '{ST_LINE_END, 0, 0, 0}));
        dir_rows.push_back(hdr_row("+IPD, :", 1, 1, 8'h00, 1, '{ST_BAD_FORMAT, 0, 0, 0}));
        dir_rows.push_back(hdr_row("+IPD,+,", 1, 1, 8'h00, 1, '{ST_BAD_FORMAT, 0, 0, 0}));
        dir_rows.push_back(hdr_row("+IPD,1,2,3:", 1, 1, 8'h00, 1,
                                   '{ST_BAD_FORMAT, 0, 0, 0}));
        dir_rows.push_back(hdr_row("+IPD,4", 1, 0, 8'h00, 0, '0));   // dropped by next begin
        dir_rows.push_back(hdr_row("+IPD,,5:xyz", 1, 1, 8'h00, 0, '0));
        dir_rows.push_back(hdr_row("+IPD,", 1, 1, 8'hFF, 1, '{ST_BAD_FORMAT, 0, 0, 0}));
        dir_rows.push_back(hdr_row("+", 1, 1, 8'h00, 1, '{ST_BAD_PREFIX, 0, 0, 0}));

        foreach (dir_rows[i]) begin
            b.delete();
            append_text(b, dir_rows[i].text);
            if (dir_rows[i].tail != 8'h00)
                b.push_back(dir_rows[i].tail);
            queue_line(b, dir_rows[i].open, dir_rows[i].close, dir_rows[i].pinned ? i : -1);
        end

        while (random_items < RAND_ITEMS)
            add_random_line();

        // last tenth of the items runs without idling on either side
        total      = feed_q.size();
        quiet_from = total - total / 10;

        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // drain: all items out, then the pipeline and some margin
        while (feed_q.size() != 0 || s_valid)
            @(negedge aclk);
        for (int k = 0; k < 200 && header_due_q.size() != 0; k++)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
        if (header_due_q.size() != 0) begin
            $error("%0d expected results never arrived", header_due_q.size());
            mismatch_cnt++;
        end

        $display("%0d bytes fed over %0d lines worth of items; headers: ok %0d, prefix %0d,",
                 bytes_fed, total, status_tally[ST_OK], status_tally[ST_BAD_PREFIX]);
        $display("format %0d, early end %0d; %0d mismatches",
                 status_tally[ST_BAD_FORMAT], status_tally[ST_LINE_END], mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
